// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the text console cursor writer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/tccw_pkg.sv =====
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared constants and types for the text console cursor writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tccw_pkg;

    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STEP = 4;

    localparam int CHAR_W  = 8;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CELL_W  = 16;
    localparam int ATTR_W  = 8;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CHAR_W-1:0] CHAR_TAB      = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE  = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_RETURN   = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_PRINT_HI = 8'h7E;

    localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h0F;
    localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0720;

    localparam logic REG_ATTR  = 1'b0;
    localparam logic REG_BLANK = 1'b1;

    localparam logic KIND_CELL  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [ROW_W-1:0]  prow;
        logic [COL_W-1:0]  col;
        logic [CELL_W-1:0] value;
        logic [ROW_W-1:0]  top;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

// ===== rtl/core/tccw_regs.sv =====
// ----------------------------------------------------------------------------
// tccw_regs
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tccw_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tccw_pkg::PADDR_W-1:0]  paddr,
    input  logic [tccw_pkg::PDATA_W-1:0]  pwdata,
    output logic [tccw_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [tccw_pkg::ATTR_W-1:0]   o_attr,
    output logic [tccw_pkg::CELL_W-1:0]   o_blank
);
    import tccw_pkg::*;

    logic              w_is_attr;
    logic [ATTR_W-1:0] r_attr_q;
    logic [CELL_W-1:0] r_blank;
    logic              w_wr;
    logic              w_idx;

    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite && pready;
    // Registers sit on 32-bit word boundaries.
    assign w_idx     = paddr[2];
    assign w_is_attr = (w_idx == REG_ATTR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr_q <= ATTR_RESET;
            r_blank  <= BLANK_RESET;
        end else if (w_wr) begin
            if (w_is_attr) begin
                r_attr_q <= pwdata[ATTR_W-1:0];
            end else begin
                r_blank <= pwdata[CELL_W-1:0];
            end
        end
    end

    always_comb begin
        case (w_idx)
            REG_ATTR:  prdata = {{(PDATA_W-ATTR_W){1'b0}}, r_attr_q};
            REG_BLANK: prdata = {{(PDATA_W-CELL_W){1'b0}}, r_blank};
            default:   prdata = '0;
        endcase
    end

    assign o_attr  = r_attr_q;
    assign o_blank = r_blank;

endmodule

// ===== rtl/core/tccw_cursor.sv =====
// ----------------------------------------------------------------------------
// tccw_cursor
// Input register, cursor and ring base state, and the per-item result logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module tccw_cursor (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [tccw_pkg::CHAR_W-1:0]  i_char_code,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [tccw_pkg::ATTR_W-1:0]  i_attr,
    input  logic [tccw_pkg::CELL_W-1:0]  i_blank,
    input  logic [1:0]                   i_level,
    output tccw_pkg::t_push              o_push
);
    import tccw_pkg::*;

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_char;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [ROW_W-1:0]  r_base;

    logic              w_nl, w_cr, w_tab, w_print;
    logic [COL_W:0]    w_col_ext;
    logic [COL_W:0]    w_col_step;
    logic              w_wrap;
    logic [ROW_W:0]    w_row_step;
    logic              w_scroll;
    logic [ROW_W:0]    w_sum;
    logic [ROW_W-1:0]  w_wrow;
    logic [ROW_W-1:0]  w_base_inc;
    logic [1:0]        w_need;
    logic              w_fits;
    logic              w_adv;
    t_result           w_cell;
    t_result           w_clear;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;

    always_comb begin
        w_nl    = (r_char == CHAR_NEWLINE);
        w_cr    = (r_char == CHAR_RETURN);
        w_tab   = (r_char == CHAR_TAB);
        w_print = (r_char inside {[CHAR_PRINT_LO:CHAR_PRINT_HI]});
    end

    // Column after the byte, one bit wider so that the edge can be seen.
    always_comb begin
        w_col_ext  = {1'b0, r_col};
        w_col_step = w_col_ext;
        if (w_cr) begin
            w_col_step = '0;
        end else if (w_tab) begin
            w_col_step = (w_col_ext + (COL_W+1)'(TAB_STEP)) & ~((COL_W+1)'(TAB_STEP - 1));
        end else if (w_print) begin
            w_col_step = w_col_ext + 1'b1;
        end
        w_wrap = (w_col_step >= (COL_W+1)'(COLUMNS));
    end

    always_comb begin
        w_row_step = {1'b0, r_row} + (ROW_W+1)'(w_nl || w_wrap);
        w_scroll   = (w_row_step >= (ROW_W+1)'(ROWS));
        n_col      = w_wrap ? '0 : w_col_step[COL_W-1:0];
        n_row      = w_scroll ? ROW_W'(ROWS - 1) : w_row_step[ROW_W-1:0];
    end

    // Both terms are below ROWS, so one conditional subtract wraps the sum.
    always_comb begin
        w_sum      = {1'b0, r_base} + {1'b0, r_row};
        w_wrow     = (w_sum >= (ROW_W+1)'(ROWS)) ? w_sum[ROW_W-1:0] - ROW_W'(ROWS)
                                                 : w_sum[ROW_W-1:0];
        w_base_inc = (r_base == ROW_W'(ROWS - 1)) ? '0 : r_base + 1'b1;
    end

    always_comb begin
        w_cell.kind  = KIND_CELL;
        w_cell.prow  = w_wrow;
        w_cell.col   = r_col;
        w_cell.value = {i_attr, 1'b0, r_char[6:0]};
        w_cell.top   = r_base;
        w_cell.last  = !w_scroll;

        w_clear.kind  = KIND_CLEAR;
        w_clear.prow  = r_base;
        w_clear.col   = '0;
        w_clear.value = i_blank;
        w_clear.top   = w_base_inc;
        w_clear.last  = 1'b1;

        w_need = 2'(w_print) + 2'(w_scroll);
        w_fits = ({1'b0, w_need} + {1'b0, i_level}) <= 3'd2;
        w_adv  = r_in_valid && w_fits;

        o_push.count = w_adv ? w_need : 2'd0;
        o_push.res0  = w_print ? w_cell : w_clear;
        o_push.res1  = w_clear;
    end

    assign o_ready = !r_in_valid || w_fits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
            r_base     <= '0;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_col <= n_col;
                r_row <= n_row;
                if (w_scroll) begin
                    r_base <= w_base_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_char <= i_char_code;
        end
    end

    `ASSERT_NEXT(a_scroll_bottom, w_adv && w_scroll, r_row == ROW_W'(ROWS - 1), "scroll must leave the cursor on the bottom row")
    `ASSERT_NEXT(a_base_hold, !(w_adv && w_scroll), r_base == $past(r_base), "ring base changed without a scroll")
    `ASSERT_SAME(a_state_range, 1'b1, (r_col < COL_W'(COLUMNS)) && (r_row < ROW_W'(ROWS)) && (r_base < ROW_W'(ROWS)), "cursor or ring base out of range")

endmodule

// ===== rtl/core/tccw_outbuf.sv =====
// ----------------------------------------------------------------------------
// tccw_outbuf
// Two-entry result buffer that drives the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module tccw_outbuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tccw_pkg::t_push     i_push,
    output logic [1:0]          o_level,
    output logic                o_valid,
    input  logic                i_ready,
    output tccw_pkg::t_result   o_res
);
    import tccw_pkg::*;

    logic [1:0] r_cnt;
    t_result    r_ent [2];
    logic [1:0] n_cnt;
    t_result    n_ent [2];
    logic       w_pop;
    logic [1:0] w_cnt_left;

    assign w_pop = (r_cnt != 2'd0) && i_ready;

    // Shift out the taken item, then append the new results behind the rest.
    always_comb begin
        n_ent[0]   = r_ent[0];
        n_ent[1]   = r_ent[1];
        w_cnt_left = r_cnt - {1'b0, w_pop};
        if (w_pop) begin
            n_ent[0] = r_ent[1];
        end
        if (i_push.count != 2'd0) begin
            n_ent[w_cnt_left[0]] = i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            n_ent[1] = i_push.res1;
        end
        n_cnt = w_cnt_left + i_push.count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent[0] <= n_ent[0];
        r_ent[1] <= n_ent[1];
    end

    assign o_level = r_cnt;
    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_ent[0];

    `ASSERT_SAME(a_push_room, i_push.count != 2'd0, ({1'b0, i_push.count} + {1'b0, r_cnt}) <= 3'd2, "result buffer overflow")
    `ASSERT_NEXT(a_count_track, 1'b1, r_cnt == $past(r_cnt) - $past(2'(w_pop)) + $past(i_push.count), "result count lost track")

endmodule

// ===== rtl/core/text_console_cursor_writer.sv =====
// Path: an accepted item is held in the input register until the result buffer has
// room, then its results are registered into the buffer, whose head is on the outputs.
// Throughput: one item per cycle while results are taken; one that writes a cell
// and scrolls waits until both entries of the two-entry result buffer are free.
// Reset: cursor column, cursor row and ring base row go to zero, the attribute
// to 0x0F and the blank cell to 0x0720; no clearing pass is run.
// ----------------------------------------------------------------------------
// text_console_cursor_writer
// Turns a byte stream into cell writes and row clears on a ring of text rows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_cursor_writer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tccw_pkg::PADDR_W-1:0]  paddr,
    input  logic [tccw_pkg::PDATA_W-1:0]  pwdata,
    output logic [tccw_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [tccw_pkg::CHAR_W-1:0]   i_char_code,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_result_kind,
    output logic [tccw_pkg::ROW_W-1:0]    o_physical_row,
    output logic [tccw_pkg::COL_W-1:0]    o_cell_column,
    output logic [tccw_pkg::CELL_W-1:0]   o_cell_value,
    output logic [tccw_pkg::ROW_W-1:0]    o_top_row,
    output logic                          o_last_of_run
);
    import tccw_pkg::*;

    logic [ATTR_W-1:0] w_attr;
    logic [CELL_W-1:0] w_blank;
    logic [1:0]        w_level;
    t_push             w_push;
    t_result           w_res;

    tccw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_attr  (w_attr),
        .o_blank (w_blank)
    );

    tccw_cursor u_cursor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char_code (i_char_code),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_attr      (w_attr),
        .i_blank     (w_blank),
        .i_level     (w_level),
        .o_push      (w_push)
    );

    tccw_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_level (w_level),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (w_res)
    );

    assign o_result_kind  = w_res.kind;
    assign o_physical_row = w_res.prow;
    assign o_cell_column  = w_res.col;
    assign o_cell_value   = w_res.value;
    assign o_top_row      = w_res.top;
    assign o_last_of_run  = w_res.last;

endmodule

// ===== verif/text_console_cursor_writer_tb.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_writer_tb
// Feeds character bytes to the cursor writer and checks every cell write and
// row clear against a cursor and ring model kept inside this bench. The run
// goes through several attribute and blank settings written over the register
// port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_cursor_writer_tb;

    import tccw_pkg::*;

    localparam int SETTLE_CYCLES = 8;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [CHAR_W-1:0]    i_char_code = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic                 o_result_kind;
    logic [ROW_W-1:0]     o_physical_row;
    logic [COL_W-1:0]     o_cell_column;
    logic [CELL_W-1:0]    o_cell_value;
    logic [ROW_W-1:0]     o_top_row;
    logic                 o_last_of_run;

    text_console_cursor_writer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_char_code    (i_char_code),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_kind  (o_result_kind),
        .o_physical_row (o_physical_row),
        .o_cell_column  (o_cell_column),
        .o_cell_value   (o_cell_value),
        .o_top_row      (o_top_row),
        .o_last_of_run  (o_last_of_run)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Screen state as the bench sees it.
    int                cur_col = 0;
    int                cur_row = 0;
    int                base_row = 0;
    logic [ATTR_W-1:0] attr = ATTR_RESET;
    logic [CELL_W-1:0] blank = BLANK_RESET;

    logic [CHAR_W-1:0] char_q[$];
    t_result           screen_ops_due[$];

    int send_idle_pct = 30;
    int recv_stall_pct = 30;
    int fail_count = 0;
    int items_taken = 0;
    int cells_seen = 0;
    int clears_seen = 0;
    int scrolls = 0;
    int settings_used = 1;

    // Applies one byte to the cursor and queues the cell write and row clear it causes.
    task automatic advance_cursor(input logic [CHAR_W-1:0] ch);
        int      col;
        int      row;
        bit      wrote;
        t_result cell_op;
        t_result clr;
        col = cur_col;
        row = cur_row;
        wrote = 1'b0;
        cell_op = '0;
        clr = '0;
        if (ch == CHAR_NEWLINE) begin
            row++;
        end else if (ch == CHAR_RETURN) begin
            col = 0;
        end else if (ch == CHAR_TAB) begin
            col = (col + TAB_STEP) & ~(TAB_STEP - 1);
        end else if (ch >= CHAR_PRINT_LO && ch <= CHAR_PRINT_HI) begin
            wrote = 1'b1;
            cell_op.kind = KIND_CELL;
            cell_op.prow = ROW_W'((base_row + row) % ROWS);
            cell_op.col = COL_W'(col);
            cell_op.value = {attr, 1'b0, ch[6:0]};
            cell_op.top = ROW_W'(base_row);
            cell_op.last = 1'b1;
            col++;
        end
        if (col >= COLUMNS) begin
            col = 0;
            row++;
        end
        if (row >= ROWS) begin
            // The row leaving the top of the screen becomes the new bottom row.
            clr.kind = KIND_CLEAR;
            clr.prow = ROW_W'(base_row);
            clr.col = '0;
            clr.value = blank;
            base_row = (base_row + 1) % ROWS;
            clr.top = ROW_W'(base_row);
            clr.last = 1'b1;
            row = ROWS - 1;
            scrolls++;
            if (wrote) begin
                cell_op.last = 1'b0;
                screen_ops_due.push_back(cell_op);
            end
            screen_ops_due.push_back(clr);
        end else if (wrote) begin
            screen_ops_due.push_back(cell_op);
        end
        cur_col = col;
        cur_row = row;
    endtask

    task automatic check_field(input string name, input int exp, input int act);
        if (exp != act) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp, act);
            fail_count++;
        end
    endtask

    // Sender.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_char_code <= '0;
        end else begin
            if (i_valid && o_ready) begin
                advance_cursor(i_char_code);
                items_taken++;
            end
            if (!i_valid || o_ready) begin
                if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_char_code <= char_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver and result checker.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (screen_ops_due.size() == 0) begin
                    $error("result with no item waiting for it: kind %0d row %0d col %0d",
                           o_result_kind, o_physical_row, o_cell_column);
                    fail_count++;
                end else begin
                    t_result want;
                    want = screen_ops_due.pop_front();
                    check_field("result_kind", want.kind, o_result_kind);
                    check_field("physical_row", want.prow, o_physical_row);
                    check_field("cell_column", want.col, o_cell_column);
                    check_field("cell_value", want.value, o_cell_value);
                    check_field("top_row", want.top, o_top_row);
                    check_field("last_of_run", want.last, o_last_of_run);
                    if (want.kind == KIND_CLEAR) clears_seen++;
                    else cells_seen++;
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic wait_drained();
        while (char_q.size() != 0 || i_valid || screen_ops_due.size() != 0)
            @(posedge i_clk);
        // Ignored bytes leave nothing to wait for, so give the pipeline time to empty.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write followed by a read back of the same register.
    task automatic write_register(input logic idx, input logic [PDATA_W-1:0] data);
        logic [PDATA_W-1:0] readback;
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_ATTR) begin
            attr = data[ATTR_W-1:0];
            readback = {{(PDATA_W-ATTR_W){1'b0}}, attr};
        end else begin
            blank = data[CELL_W-1:0];
            readback = {{(PDATA_W-CELL_W){1'b0}}, blank};
        end
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("prdata", readback, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic change_setting(input logic [PDATA_W-1:0] a, input logic [PDATA_W-1:0] b);
        wait_drained();
        write_register(REG_ATTR, a);
        write_register(REG_BLANK, b);
        settings_used++;
    endtask

    // Random text: printable runs that wrap, whole lines, newline bursts that
    // scroll, tab runs that cross the right edge, and some arbitrary bytes.
    task automatic queue_random_text(input int target);
        int                counted;
        int                pick;
        int                len;
        logic [CHAR_W-1:0] ch;
        counted = 0;
        while (counted < target) begin
            pick = $urandom_range(99);
            if (pick < 35) len = $urandom_range(1, 90);
            else if (pick < 50) len = $urandom_range(1, 30);
            else if (pick < 70) len = $urandom_range(2, 40);
            else if (pick < 82) len = $urandom_range(1, 22);
            else len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++) begin
                if (pick < 35) begin
                    ch = CHAR_W'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI));
                end else if (pick < 50) begin
                    ch = CHAR_NEWLINE;
                end else if (pick < 70) begin
                    // A text line ends in return and newline.
                    if (k == len - 2) ch = CHAR_RETURN;
                    else if (k == len - 1) ch = CHAR_NEWLINE;
                    else ch = CHAR_W'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI));
                end else if (pick < 82) begin
                    ch = CHAR_TAB;
                end else begin
                    ch = CHAR_W'($urandom_range(255));
                end
                char_q.push_back(ch);
                if (ch == CHAR_NEWLINE || ch == CHAR_RETURN || ch == CHAR_TAB ||
                    (ch >= CHAR_PRINT_LO && ch <= CHAR_PRINT_HI))
                    counted++;
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Edges of the byte range, every control byte that acts, and some that do not.
        char_q = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h1F, CHAR_PRINT_LO, CHAR_PRINT_HI,
                   8'h41, CHAR_TAB, CHAR_TAB, 8'h5A, CHAR_RETURN, CHAR_NEWLINE,
                   8'h08, 8'h0B, 8'h0C, 8'h0E, 8'hA5, CHAR_TAB, 8'h61, CHAR_NEWLINE};
        queue_random_text(250);
        wait_drained();

        change_setting(32'h0000_0000, 32'h0000_0000);
        queue_random_text(265);

        // Long stretch with neither side idling, at the all-ones setting.
        change_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_random_text(265);

        change_setting($urandom, $urandom);
        send_idle_pct = 30;
        recv_stall_pct = 30;
        queue_random_text(265);

        change_setting($urandom, $urandom);
        queue_random_text(265);
        wait_drained();

        $display("Accepted %0d bytes over %0d settings, causing %0d scrolls.",
                 items_taken, settings_used, scrolls);
        $display("Checked %0d cell writes and %0d row clears.", cells_seen, clears_seen);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/tccw_pkg.sv
rtl/core/tccw_regs.sv
rtl/core/tccw_cursor.sv
rtl/core/tccw_outbuf.sv
rtl/core/text_console_cursor_writer.sv
verif/text_console_cursor_writer_tb.sv
